@@ rtl/core/sia_pkg.sv @@
// Package for the signed integer ALU: opcodes, error codes and widths.
// No dependencies; used by every module in rtl/core.
package sia_pkg;
    localparam int unsigned DataW  = 64;
    localparam int unsigned MagW   = 64;

    typedef enum logic [3:0] {
        CMD_ADD = 4'd0,  CMD_SUB = 4'd1,  CMD_MUL = 4'd2,  CMD_DIV = 4'd3,
        CMD_MOD = 4'd4,  CMD_LT  = 4'd5,  CMD_GT  = 4'd6,  CMD_LE  = 4'd7,
        CMD_GE  = 4'd8,  CMD_EQ  = 4'd9,  CMD_NE  = 4'd10, CMD_CMP = 4'd11,
        CMD_NEG = 4'd12, CMD_R13 = 4'd13, CMD_R14 = 4'd14, CMD_R15 = 4'd15
    } t_cmd;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_DIV0 = 2'd1,
        ERR_MOD0 = 2'd2,
        ERR_RSVD = 2'd3
    } t_err;

    // Per-item control carried alongside the datapath
    typedef struct packed {
        t_cmd cmd;
        logic a_neg;
        logic b_neg;
        logic b_zero;
    } t_ctl;
endpackage

@@ rtl/core/signed_integer_alu_unit.sv @@
// Top level of the signed 64-bit integer ALU.
// Depends on sia_pkg and sia_div.
//
// One item (opcode, two signed 64-bit operands) enters per cycle; each
// produces one result with an error code through 66 register stages: one
// input stage, 64 divider stages (one quotient bit each, which sets the depth)
// and one output register that also takes the sign fix and the result select.
// Other opcodes, the 32x32 partial-product multiply among them, ride alongside
// in delay lines.
// The whole pipe advances whenever the output register is empty or taken,
// so throughput is one item per cycle without back-pressure.
module signed_integer_alu_unit
    import sia_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [3:0]              i_cmd,
    input  logic signed [DataW-1:0] i_lhs,
    input  logic signed [DataW-1:0] i_rhs,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [DataW-1:0] o_result,
    output logic [1:0]              o_error
);
    // Delay lines match the divider stage count
    localparam int unsigned Depth = MagW;

    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en && i_rst_n;

    // Input stage: register operands, magnitudes and flags
    logic            r_v0;
    t_ctl            r_c0;
    logic [DataW-1:0] r_a0, r_b0, r_ma0, r_mb0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v0 <= 1'b0;
        else if (en) r_v0 <= i_valid;
        if (en) begin
            r_c0.cmd    <= t_cmd'(i_cmd);
            r_c0.a_neg  <= i_lhs[DataW-1];
            r_c0.b_neg  <= i_rhs[DataW-1];
            r_c0.b_zero <= (i_rhs == '0);
            r_a0  <= i_lhs;
            r_b0  <= i_rhs;
            r_ma0 <= i_lhs[DataW-1] ? -i_lhs : i_lhs;
            r_mb0 <= i_rhs[DataW-1] ? -i_rhs : i_rhs;
        end
    end

    // Non-divide, non-multiply result, computed combinationally from stage 0
    logic [DataW-1:0] n_simple;
    logic             lt, gt;
    always_comb begin
        lt = $signed(r_a0) < $signed(r_b0);
        gt = $signed(r_b0) < $signed(r_a0);
        unique case (r_c0.cmd)
            CMD_ADD: n_simple = r_a0 + r_b0;
            CMD_SUB: n_simple = r_a0 - r_b0;
            CMD_LT:  n_simple = DataW'(lt);
            CMD_GT:  n_simple = DataW'(gt);
            CMD_LE:  n_simple = DataW'(!gt);
            CMD_GE:  n_simple = DataW'(!lt);
            CMD_EQ:  n_simple = DataW'(r_a0 == r_b0);
            CMD_NE:  n_simple = DataW'(r_a0 != r_b0);
            CMD_CMP: n_simple = gt ? DataW'(1) : (lt ? '1 : '0);
            CMD_NEG: n_simple = -r_a0;
            default: n_simple = '0;
        endcase
    end

    // Multiply: three 32x32 partial products, then sum next stage
    logic [DataW-1:0] r_pll, r_plh, r_phl, r_mul;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pll <= r_a0[31:0] * r_b0[31:0];
            r_plh <= {r_a0[31:0] * r_b0[63:32], 32'd0};
            r_phl <= {r_a0[63:32] * r_b0[31:0], 32'd0};
            r_mul <= r_pll + r_plh + r_phl;
        end
    end

    // Divider on magnitudes
    logic [MagW-1:0] quo, rem;
    sia_div u_div (
        .i_clk (i_clk), .i_en (en), .i_num (r_ma0), .i_den (r_mb0),
        .o_quo (quo), .o_rem (rem)
    );

    // Delay lines for control, valid and simple result
    logic             r_vd [Depth];
    t_ctl             r_cd [Depth];
    logic [DataW-1:0] r_sd [Depth];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < Depth; k++) r_vd[k] <= 1'b0;
        end else if (en) begin
            r_vd[0] <= r_v0;
            for (int k = 1; k < Depth; k++) r_vd[k] <= r_vd[k-1];
        end
        if (en) begin
            r_cd[0] <= r_c0;
            r_sd[0] <= n_simple;
            for (int k = 1; k < Depth; k++) begin
                r_cd[k] <= r_cd[k-1];
                r_sd[k] <= (k == 2 && r_cd[1].cmd == CMD_MUL) ? r_mul : r_sd[k-1];
            end
        end
    end

    // Final stage: sign fix, special divisors, select
    t_ctl             c;
    logic [DataW-1:0] n_res;
    t_err             n_err;
    always_comb begin
        c     = r_cd[Depth-1];
        n_err = ERR_NONE;
        n_res = r_sd[Depth-1];
        if (c.cmd == CMD_DIV) begin
            priority if (c.b_zero) begin
                n_res = '0; n_err = ERR_DIV0;
            end else if (c.a_neg != c.b_neg) n_res = -quo;
            else n_res = quo;
        end else if (c.cmd == CMD_MOD) begin
            priority if (c.b_zero) begin
                n_res = '0; n_err = ERR_MOD0;
            end else if (c.a_neg) n_res = -rem;
            else n_res = rem;
        end
    end

    // Output register
    logic r_ov;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (en) r_ov <= r_vd[Depth-1];
        if (en) begin
            o_result <= n_res;
            o_error  <= n_err;
        end
    end
    assign o_valid = r_ov;

    // Divide by -1: magnitude path gives |a|, sign fix yields -a, matching wrap.
    // Remainder by -1 is 0 naturally.

    property p_hold;
        @(posedge i_clk) disable iff (!i_rst_n) (o_valid && !i_ready) |=> o_valid;
    endproperty
    a_hold: assert property (p_hold) else $error("result dropped under stall");

    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_error != ERR_RSVD))
        else $error("reserved error code");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("pipe stalled with empty output");

    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_vd[Depth-1]) |=> o_valid)
        else $error("item lost at output");
endmodule

@@ rtl/core/sia_div.sv @@
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on sia_pkg.
module sia_div
    import sia_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [MagW-1:0]   i_num,
    input  logic [MagW-1:0]   i_den,
    output logic [MagW-1:0]   o_quo,
    output logic [MagW-1:0]   o_rem
);
    // stage s holds partial remainder, shifting numerator, and divisor
    logic [MagW-1:0] r_rem [MagW+1];
    logic [MagW-1:0] r_num [MagW+1];
    logic [MagW-1:0] r_den [MagW+1];

    assign r_rem[0] = '0;
    assign r_num[0] = i_num;
    assign r_den[0] = i_den;

    // Advance one quotient bit per register stage
    for (genvar s = 0; s < MagW; s++) begin : g_stage
        logic [MagW:0]   n_trial;
        logic [MagW:0]   n_diff;
        logic [MagW-1:0] r_srem;
        logic [MagW-1:0] r_snum;
        logic [MagW-1:0] r_sden;
        always_comb begin
            n_trial = {r_rem[s], r_num[s][MagW-1]};
            n_diff  = n_trial - {1'b0, r_den[s]};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sden <= r_den[s];
                if (n_diff[MagW]) begin
                    r_srem <= n_trial[MagW-1:0];
                    r_snum <= {r_num[s][MagW-2:0], 1'b0};
                end else begin
                    r_srem <= n_diff[MagW-1:0];
                    r_snum <= {r_num[s][MagW-2:0], 1'b1};
                end
            end
        end
        assign r_rem[s+1] = r_srem;
        assign r_num[s+1] = r_snum;
        assign r_den[s+1] = r_sden;
    end

    assign o_quo = r_num[MagW];
    assign o_rem = r_rem[MagW];
endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for signed_integer_alu_unit: directed table, then random items.
// Depends on sia_pkg and the RTL of signed_integer_alu_unit.
`timescale 1ns / 1ps

module testbench;
    import sia_pkg::*;

    localparam int unsigned Latency   = 65;
    localparam int unsigned StallMax  = 20000;
    localparam int unsigned RandItems = 1850;
    localparam logic [63:0] MinVal = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MaxVal = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] AllOne = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        t_cmd        cmd;
        logic [63:0] lhs;
        logic [63:0] rhs;
    } t_op;

    typedef struct {
        logic [63:0] result;
        t_err        err;
    } t_res;

    typedef struct {
        t_op  op;
        bit   typed;
        t_res res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [3:0]  i_cmd;
    logic signed [63:0] i_lhs;
    logic signed [63:0] i_rhs;
    logic        o_valid;
    logic        i_ready;
    logic signed [63:0] o_result;
    logic [1:0]  o_error;

    signed_integer_alu_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_cmd   (i_cmd),
        .i_lhs   (i_lhs),
        .i_rhs   (i_rhs),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_result(o_result),
        .o_error (o_error)
    );

    t_res        pending_q[$];
    t_row        dir_rows[$];
    int unsigned mismatches = 0;
    int unsigned idle_cycles = 0;

    // Clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic logic [63:0] magnitude(logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    // Compute the expected result of one operation
    function automatic t_res alu_predict(t_op op);
        t_res r;
        logic signed [63:0] sa, sb;
        logic [63:0] q;
        sa = op.lhs;
        sb = op.rhs;
        r.result = '0;
        r.err = ERR_NONE;
        case (op.cmd)
            CMD_ADD: r.result = op.lhs + op.rhs;
            CMD_SUB: r.result = op.lhs - op.rhs;
            CMD_MUL: r.result = op.lhs * op.rhs;
            CMD_DIV: begin
                if (op.rhs == 0) begin
                    r.err = ERR_DIV0;
                end else if (op.rhs == AllOne) begin
                    r.result = 64'd0 - op.lhs;
                end else begin
                    q = magnitude(op.lhs) / magnitude(op.rhs);
                    r.result = (op.lhs[63] != op.rhs[63]) ? (64'd0 - q) : q;
                end
            end
            CMD_MOD: begin
                if (op.rhs == 0) begin
                    r.err = ERR_MOD0;
                end else if (op.rhs != AllOne) begin
                    q = magnitude(op.lhs) % magnitude(op.rhs);
                    r.result = op.lhs[63] ? (64'd0 - q) : q;
                end
            end
            CMD_LT:  r.result = {63'd0, sa < sb};
            CMD_GT:  r.result = {63'd0, sa > sb};
            CMD_LE:  r.result = {63'd0, sa <= sb};
            CMD_GE:  r.result = {63'd0, sa >= sb};
            CMD_EQ:  r.result = {63'd0, sa == sb};
            CMD_NE:  r.result = {63'd0, sa != sb};
            CMD_CMP: r.result = (sa > sb) ? 64'd1 : ((sa < sb) ? AllOne : 64'd0);
            CMD_NEG: r.result = 64'd0 - op.lhs;
            default: r.result = '0;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic logic [63:0] rand_operand();
        case ($urandom_range(0, 9))
            0: return MinVal;
            1: return MaxVal;
            2: return AllOne;
            3: return 64'd0;
            4: return 64'd1;
            5: return {{60{$urandom_range(0, 1) == 1}}, 4'($urandom)};
            6: return 64'($urandom_range(0, 200)) - 64'd100;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic add_row(t_cmd c, logic [63:0] a, logic [63:0] b, bit typed = 0,
                           logic [63:0] res = 0, t_err e = ERR_NONE);
        t_row row;
        row.op.cmd = c;
        row.op.lhs = a;
        row.op.rhs = b;
        row.typed = typed;
        row.res.result = res;
        row.res.err = e;
        dir_rows.push_back(row);
    endtask

    // Present one item and hold it until accepted
    task automatic send_op(t_op op, bit typed, t_res want);
        i_valid <= 1'b1;
        i_cmd   <= op.cmd;
        i_lhs   <= op.lhs;
        i_rhs   <= op.rhs;
        do @(posedge i_clk); while (!o_ready);
        pending_q.push_back(typed ? want : alu_predict(op));
        @(negedge i_clk);
    endtask

    // Receiver: stall on its own pattern and check each result
    initial begin
        int unsigned phase;
        i_ready = 1'b0;
        phase = 0;
        forever begin
            @(negedge i_clk);
            phase++;
            if (phase % 512 < 128) i_ready <= 1'b1;
            else i_ready <= ($urandom_range(0, 3) != 0) && (phase % 37 != 0);
        end
    end

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected result", o_result, 64'd0);
            end else begin
                want = pending_q.pop_front();
                if (o_result !== want.result)
                    report_mismatch("result", o_result, want.result);
                if (o_error !== want.err)
                    report_mismatch("error", 64'(o_error), 64'(want.err));
            end
        end
    end

    // Watchdog on cycles with no accepted item
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > StallMax) begin
            $display("** signed_integer_alu_unit: FAILED **");
            $finish;
        end
    end

    // Sender
    initial begin
        t_op  op;
        t_res none;
        int unsigned sent, burst;
        none.result = '0;
        none.err = ERR_NONE;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_cmd = '0;
        i_lhs = '0;
        i_rhs = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: extremes, every opcode, special divisors
        add_row(CMD_ADD, MaxVal, 64'd1, 1, MinVal);
        add_row(CMD_SUB, MinVal, 64'd1, 1, MaxVal);
        add_row(CMD_MUL, MinVal, AllOne, 1, MinVal);
        add_row(CMD_MUL, MaxVal, MaxVal);
        add_row(CMD_DIV, MinVal, AllOne, 1, MinVal);
        add_row(CMD_DIV, 64'd7, 64'd0, 1, 64'd0, ERR_DIV0);
        add_row(CMD_DIV, 64'd0 - 64'd7, 64'd2, 1, 64'd0 - 64'd3);
        add_row(CMD_DIV, MinVal, 64'd2);
        add_row(CMD_MOD, MinVal, AllOne, 1, 64'd0);
        add_row(CMD_MOD, MaxVal, 64'd0, 1, 64'd0, ERR_MOD0);
        add_row(CMD_MOD, 64'd0 - 64'd7, 64'd2, 1, AllOne);
        add_row(CMD_MOD, MinVal, MaxVal);
        add_row(CMD_LT, MinVal, MaxVal, 1, 64'd1);
        add_row(CMD_GT, MinVal, MaxVal, 1, 64'd0);
        add_row(CMD_LE, AllOne, AllOne, 1, 64'd1);
        add_row(CMD_GE, AllOne, 64'd0, 1, 64'd0);
        add_row(CMD_EQ, MinVal, MinVal, 1, 64'd1);
        add_row(CMD_NE, MinVal, MinVal, 1, 64'd0);
        add_row(CMD_CMP, MinVal, MaxVal, 1, AllOne);
        add_row(CMD_CMP, MaxVal, MinVal, 1, 64'd1);
        add_row(CMD_CMP, 64'd5, 64'd5, 1, 64'd0);
        add_row(CMD_NEG, MinVal, AllOne, 1, MinVal);
        add_row(CMD_R13, AllOne, AllOne, 1, 64'd0);
        add_row(CMD_R14, MaxVal, 64'd0, 1, 64'd0);
        add_row(CMD_R15, MinVal, MinVal, 1, 64'd0);
        foreach (dir_rows[k]) send_op(dir_rows[k].op, dir_rows[k].typed, dir_rows[k].res);

        // Random items in bursts with gaps
        sent = 0;
        while (sent < RandItems) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                op.cmd = t_cmd'($urandom_range(0, 15) < 14 ? $urandom_range(0, 12)
                                                            : $urandom_range(13, 15));
                op.lhs = rand_operand();
                op.rhs = ($urandom_range(0, 7) == 0) ? op.lhs : rand_operand();
                send_op(op, 0, none);
                sent++;
            end
            if (sent > RandItems / 2 && sent - burst <= RandItems / 2) begin
                // Hold off until the pipe has drained
                i_valid <= 1'b0;
                while (pending_q.size() != 0) @(negedge i_clk);
            end else if ($urandom_range(0, 2) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
        end
        i_valid <= 1'b0;

        // Drain and settle
        while (pending_q.size() != 0) @(negedge i_clk);
        repeat (Latency + 10) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("** signed_integer_alu_unit: PASSED **");
        end else begin
            $display("** signed_integer_alu_unit: FAILED **");
        end
        $finish;
    end
endmodule
